@@ hdl/hdg_pkg.sv @@
package hdg_pkg;

   // Command codes on the request channel
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Outcome codes on the response channel
   typedef logic [2:0] outcome_type;
   localparam outcome_type OC_IDLE    = 3'd0;
   localparam outcome_type OC_DESC    = 3'd1;
   localparam outcome_type OC_OK      = 3'd2;
   localparam outcome_type OC_REV     = 3'd3;
   localparam outcome_type OC_STALL   = 3'd4;
   localparam outcome_type OC_TIMEOUT = 3'd5;
   localparam outcome_type OC_BUSY    = 3'd6;

   // Register file
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_TIMEOUT_MS   = 3'd0;
   localparam csr_index_type CSR_STALL_MS     = 3'd1;
   localparam csr_index_type CSR_MIN_PROGRESS = 3'd2;
   localparam csr_index_type CSR_REVERSE      = 3'd3;
   localparam csr_index_type CSR_DRIVE_DUTY   = 3'd4;

   localparam logic [15:0] TIMEOUT_MS_RESET   = 16'd20000;
   localparam logic [15:0] STALL_MS_RESET     = 16'd300;
   localparam logic [15:0] MIN_PROGRESS_RESET = 16'd20;
   localparam logic [15:0] REVERSE_RESET      = 16'd50;
   localparam logic [7:0]  DRIVE_DUTY_RESET   = 8'd255;

   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [15:0] stall_ms;
      logic [15:0] min_progress;
      logic [15:0] reverse_counts;
      logic [7:0]  drive_duty;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic calibrated;
      logic fault;
   } flags_type;

   typedef struct packed {
      outcome_type outcome;
      logic [7:0]  motor_duty;
      logic        direction_down;
      logic        zero_position;
      logic        calibrated;
      logic        fault_hold;
   } result_type;

endpackage

@@ hdl/hdg_if.sv @@
interface hdg_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic        limit_active;
   logic [31:0] enc_count;

   modport source (output valid, output cmd, output limit_active, output enc_count,
                   input ready);
   modport sink (input valid, input cmd, input limit_active, input enc_count,
                 output ready);
endinterface

interface hdg_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] outcome;
   logic [7:0] motor_duty;
   logic       direction_down;
   logic       zero_position;
   logic       calibrated;
   logic       fault_hold;

   modport source (output valid, output outcome, output motor_duty, output direction_down,
                   output zero_position, output calibrated, output fault_hold,
                   input ready);
   modport sink (input valid, input outcome, input motor_duty, input direction_down,
                 input zero_position, input calibrated, input fault_hold,
                 output ready);
endinterface

@@ hdl/hdg_regs.sv @@
module hdg_regs
   import hdg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT_MS:   cfg_in.timeout_ms     = csr_wdata;
            CSR_STALL_MS:     cfg_in.stall_ms       = csr_wdata;
            CSR_MIN_PROGRESS: cfg_in.min_progress   = csr_wdata;
            CSR_REVERSE:      cfg_in.reverse_counts = csr_wdata;
            CSR_DRIVE_DUTY:   cfg_in.drive_duty     = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms     <= TIMEOUT_MS_RESET;
         cfg_ff.stall_ms       <= STALL_MS_RESET;
         cfg_ff.min_progress   <= MIN_PROGRESS_RESET;
         cfg_ff.reverse_counts <= REVERSE_RESET;
         cfg_ff.drive_duty     <= DRIVE_DUTY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/hdg_step.sv @@
module hdg_step
   import hdg_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
)(
   input  cfg_type                       cfg,
   input  logic                          cmd,
   input  logic                          limit_active,
   input  logic signed [COUNT_WIDTH-1:0] count,
   input  flags_type                     flags,
   input  logic signed [COUNT_WIDTH-1:0] start_count,
   input  logic signed [COUNT_WIDTH-1:0] mark_count,
   input  logic [15:0]                   elapsed_ticks,
   input  logic [15:0]                   progress_tick,
   output flags_type                     flags_next,
   output logic signed [COUNT_WIDTH-1:0] start_count_next,
   output logic signed [COUNT_WIDTH-1:0] mark_count_next,
   output logic [15:0]                   elapsed_ticks_next,
   output logic [15:0]                   progress_tick_next,
   output result_type                    result
);

   localparam int DW = COUNT_WIDTH + 2;

   logic [15:0]          elapsed_inc;
   logic signed [DW-1:0] count_x;
   logic signed [DW-1:0] rev_diff;
   logic signed [DW-1:0] rev_limit;
   logic signed [DW-1:0] prog_sum;
   logic [15:0]          idle_gap;
   logic                 timeout_hit;
   logic                 reverse_hit;
   logic                 progress_hit;
   logic                 stall_hit;
   logic                 driving;

   // saturating tick counter
   assign elapsed_inc = (elapsed_ticks == TICKS_MAX) ? elapsed_ticks : elapsed_ticks + 16'd1;
   assign timeout_hit = elapsed_inc >= cfg.timeout_ms;

   // exact differences: two extra bits hold the sign and the threshold add
   assign count_x   = DW'(count);
   assign rev_diff  = count_x - DW'(start_count);
   assign rev_limit = $signed({{(DW-16){1'b0}}, cfg.reverse_counts});
   assign reverse_hit = rev_diff > rev_limit;

   // fall of at least min counts: (count - progress) + min <= 0
   assign prog_sum = count_x - DW'(mark_count)
                   + $signed({{(DW-16){1'b0}}, cfg.min_progress});
   assign progress_hit = prog_sum <= DW'(0);

   // progress_tick never passes elapsed, so this cannot wrap
   assign idle_gap  = elapsed_inc - progress_tick;
   assign stall_hit = !progress_hit && (idle_gap >= cfg.stall_ms);

   always_comb begin
      flags_next          = flags;
      start_count_next    = start_count;
      mark_count_next     = mark_count;
      elapsed_ticks_next  = elapsed_ticks;
      progress_tick_next  = progress_tick;
      result.outcome       = OC_IDLE;
      result.zero_position = 1'b0;
      driving              = 1'b0;

      if (cmd == CMD_START) begin
         priority if (flags.busy) begin
            result.outcome = OC_BUSY;
            driving        = 1'b1;
         end else if (limit_active) begin
            flags_next.calibrated = 1'b1;
            result.outcome        = OC_OK;
            result.zero_position  = 1'b1;
         end else begin
            flags_next.busy     = 1'b1;
            start_count_next    = count;
            mark_count_next     = count;
            elapsed_ticks_next  = '0;
            progress_tick_next  = '0;
            result.outcome      = OC_DESC;
            driving             = 1'b1;
         end
      end else if (flags.busy) begin
         elapsed_ticks_next = elapsed_inc;
         priority if (timeout_hit) begin
            flags_next.busy = 1'b0;
            result.outcome  = OC_TIMEOUT;
         end else if (reverse_hit) begin
            flags_next.busy  = 1'b0;
            flags_next.fault = 1'b1;
            result.outcome   = OC_REV;
         end else if (stall_hit) begin
            flags_next.busy = 1'b0;
            result.outcome  = OC_STALL;
         end else begin
            if (progress_hit) begin
               mark_count_next    = count;
               progress_tick_next = elapsed_inc;
            end
            if (limit_active) begin
               flags_next.busy       = 1'b0;
               flags_next.calibrated = 1'b1;
               result.outcome        = OC_OK;
               result.zero_position  = 1'b1;
            end else begin
               result.outcome = OC_DESC;
               driving        = 1'b1;
            end
         end
      end

      result.motor_duty     = driving ? cfg.drive_duty : 8'd0;
      result.direction_down = driving;
      result.calibrated     = flags_next.calibrated;
      result.fault_hold     = flags_next.fault;
   end

endmodule

@@ hdl/homing_descent_guard_core.sv @@
// Channel   Dir  Handshake              Payload
// req_chan  in   valid/ready            cmd, limit_active, enc_count[31:0]
// rsp_chan  out  valid/ready            outcome, motor_duty, direction_down,
//                                       zero_position, calibrated, fault_hold
// csr_*     in   csr_we (no wait)       csr_index[2:0], csr_wdata[15:0]
//
// One transaction per cycle while rsp_chan.ready stays high; a request passes the input
// register and then the result register before its response is presented on rsp_chan.
// The guard checks are one pass of compares and adds between those registers.
// Reset is synchronous, active high: descent idle, flags clear, registers at defaults.
// A stalled response holds the pipe; the input register still takes one more
// request, so req_chan.ready drops only when both stages are full.
module homing_descent_guard_core
   import hdg_pkg::*;
#(
   parameter int COUNT_WIDTH = 32   // encoder bits used, 16..32, sign-extended
)(
   input  logic                      clock,
   input  logic                      reset,
   hdg_req_if.sink                   req_chan,
   hdg_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   cfg_type cfg;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic                          in_cmd_ff;
   logic                          in_limit_ff;
   logic signed [COUNT_WIDTH-1:0] in_count_ff;

   // descent state
   flags_type                     flags_ff, flags_in;
   logic signed [COUNT_WIDTH-1:0] start_count_ff, start_count_in;
   logic signed [COUNT_WIDTH-1:0] mark_count_ff, mark_count_in;
   logic [15:0]                   elapsed_ticks_ff, elapsed_ticks_in;
   logic [15:0]                   progress_tick_ff, progress_tick_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;

   logic req_take;
   logic advance;

   hdg_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hdg_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cfg                 (cfg),
      .cmd                 (in_cmd_ff),
      .limit_active        (in_limit_ff),
      .count               (in_count_ff),
      .flags               (flags_ff),
      .start_count         (start_count_ff),
      .mark_count          (mark_count_ff),
      .elapsed_ticks       (elapsed_ticks_ff),
      .progress_tick       (progress_tick_ff),
      .flags_next          (flags_in),
      .start_count_next    (start_count_in),
      .mark_count_next     (mark_count_in),
      .elapsed_ticks_next  (elapsed_ticks_in),
      .progress_tick_next  (progress_tick_in),
      .result              (result_in)
   );

   // the held request moves into the result register when that slot frees up
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_chan.cmd;
         in_limit_ff <= req_chan.limit_active;
         in_count_ff <= $signed(req_chan.enc_count[COUNT_WIDTH-1:0]);
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // state commits only when a transaction is actually processed
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff          <= '0;
         start_count_ff    <= '0;
         mark_count_ff     <= '0;
         elapsed_ticks_ff  <= '0;
         progress_tick_ff  <= '0;
      end else if (advance) begin
         flags_ff          <= flags_in;
         start_count_ff    <= start_count_in;
         mark_count_ff     <= mark_count_in;
         elapsed_ticks_ff  <= elapsed_ticks_in;
         progress_tick_ff  <= progress_tick_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.outcome        = result_ff.outcome;
   assign rsp_chan.motor_duty     = result_ff.motor_duty;
   assign rsp_chan.direction_down = result_ff.direction_down;
   assign rsp_chan.zero_position  = result_ff.zero_position;
   assign rsp_chan.calibrated     = result_ff.calibrated;
   assign rsp_chan.fault_hold     = result_ff.fault_hold;

endmodule
